### design/sfas_pkg.sv
// Package for the single-precision add/subtract core.
// Holds the transaction structs, stage structs and shared constants; no dependencies.
package sfas_pkg;

  localparam logic [22:0] QNAN_FRAC = 23'h400000;
  localparam logic [7:0] EXP_MAX = 8'hFF;

  typedef struct packed {
    logic        req_type;
    logic        a_sign;
    logic [7:0]  a_exponent;
    logic [22:0] a_mantissa;
    logic        b_sign;
    logic [7:0]  b_exponent;
    logic [22:0] b_mantissa;
  } sfas_in_t;

  typedef struct packed {
    logic        sum_sign;
    logic [7:0]  sum_exponent;
    logic [22:0] sum_mantissa;
    logic        exception_flag;
  } sfas_out_t;

  // Stage 1 to stage 2: operands ordered by magnitude, early result if any.
  typedef struct packed {
    logic        done;
    sfas_out_t   early;
    logic        eff_sub;
    logic        sx;
    logic [7:0]  ex;
    logic [23:0] mx;
    logic [23:0] my;
    logic [7:0]  d;
  } sfas_ord_t;

  // Stage 2 to stage 3: raw magnitude sum, 63 bits with sticky.
  typedef struct packed {
    logic        done;
    sfas_out_t   early;
    logic        sx;
    logic [7:0]  ex;
    logic [62:0] r;
  } sfas_sum_t;

endpackage

### design/single_float_add_sub_core.sv
// Top level of the single-precision add/subtract core.
// Depends on sfas_pkg, sfas_align and sfas_norm.
//
// Usage: drive in_data and raise start; the transaction is taken at any
// rising edge where start is high and busy is low. Busy is always low, so
// one transaction may be issued every cycle.
// Each result appears on out_data for exactly one cycle with out_valid high,
// once its transaction has passed all four register stages, in issue order.
// The pipeline has four register stages: ordering and special cases,
// alignment shift and magnitude add, leading-one search, normalize and pack.
// The receiver cannot stall; every result must be taken when shown.
// Throughput is one transaction per cycle.
// Synchronous reset clears all valid bits, so no result appears for work
// in flight at reset.
module single_float_add_sub_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  sfas_pkg::sfas_in_t  in_data,
  output logic                out_valid,
  output sfas_pkg::sfas_out_t out_data
);
  import sfas_pkg::*;

  logic      mid_valid;
  sfas_sum_t mid_data;

  assign busy = 1'b0;

  sfas_align u_align (
    .clk(clk), .rst_n(rst_n), .in_valid(start & ~busy), .in_data(in_data),
    .mid_valid(mid_valid), .mid_data(mid_data)
  );

  sfas_norm u_norm (
    .clk(clk), .rst_n(rst_n), .mid_valid(mid_valid), .mid_data(mid_data),
    .out_valid(out_valid), .out_data(out_data)
  );
endmodule

### design/sfas_align.sv
// Front stages: special cases, magnitude ordering, alignment shift and add.
// Depends on sfas_pkg.
module sfas_align (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  sfas_pkg::sfas_in_t in_data,
  output logic               mid_valid,
  output sfas_pkg::sfas_sum_t mid_data
);
  import sfas_pkg::*;

  logic      v1_r;
  sfas_ord_t o_r, o_nxt;
  sfas_sum_t s_r, s_nxt;
  logic      v2_r;

  logic sb;
  logic a_big;
  always_comb begin
    sb = in_data.b_sign ^ in_data.req_type;
    a_big = (in_data.a_exponent > in_data.b_exponent) ||
            ((in_data.a_exponent == in_data.b_exponent) &&
             (in_data.a_mantissa >= in_data.b_mantissa));
    o_nxt = '0;
    o_nxt.eff_sub = in_data.a_sign ^ sb;
    if (a_big) begin
      o_nxt.sx = in_data.a_sign;
      o_nxt.ex = in_data.a_exponent;
      o_nxt.mx = {1'b1, in_data.a_mantissa};
      o_nxt.my = {1'b1, in_data.b_mantissa};
      o_nxt.d = in_data.a_exponent - in_data.b_exponent;
    end else begin
      o_nxt.sx = sb;
      o_nxt.ex = in_data.b_exponent;
      o_nxt.mx = {1'b1, in_data.b_mantissa};
      o_nxt.my = {1'b1, in_data.a_mantissa};
      o_nxt.d = in_data.b_exponent - in_data.a_exponent;
    end
    o_nxt.done = 1'b1;
    if (in_data.a_exponent == EXP_MAX || in_data.b_exponent == EXP_MAX) begin
      o_nxt.early = '{1'b0, EXP_MAX, QNAN_FRAC, 1'b1};
    end else if (in_data.a_exponent == 8'd0 && in_data.b_exponent == 8'd0) begin
      o_nxt.early = '0;
    end else if (in_data.a_exponent == 8'd0) begin
      o_nxt.early = '{sb, in_data.b_exponent, in_data.b_mantissa, 1'b0};
    end else if (in_data.b_exponent == 8'd0) begin
      o_nxt.early = '{in_data.a_sign, in_data.a_exponent, in_data.a_mantissa, 1'b0};
    end else if (o_nxt.eff_sub && in_data.a_exponent == in_data.b_exponent &&
                 in_data.a_mantissa == in_data.b_mantissa) begin
      o_nxt.early = '0;
    end else begin
      o_nxt.done = 1'b0;
    end
  end

  logic [62:0] mxw, myw, sh;
  logic        sticky;
  always_comb begin
    mxw = {1'b0, o_r.mx, 38'd0};
    myw = {1'b0, o_r.my, 38'd0};
    sh = myw >> o_r.d[5:0];
    sticky = ((sh << o_r.d[5:0]) != myw);
    if (o_r.d >= 8'd63) begin
      sh = 63'd1;
    end else begin
      sh = sh | {62'd0, sticky};
    end
    s_nxt.done = o_r.done;
    s_nxt.early = o_r.early;
    s_nxt.sx = o_r.sx;
    s_nxt.ex = o_r.ex;
    s_nxt.r = o_r.eff_sub ? (mxw - sh) : (mxw + sh);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
    o_r <= o_nxt;
    s_r <= s_nxt;
  end

  assign mid_valid = v2_r;
  assign mid_data = s_r;
endmodule

### design/sfas_norm.sv
// Back stages of the adder: leading-one search, normalize shift and rounding-free packing.
// Depends on sfas_pkg.
module sfas_norm (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                mid_valid,
  input  sfas_pkg::sfas_sum_t mid_data,
  output logic                out_valid,
  output sfas_pkg::sfas_out_t out_data
);
  import sfas_pkg::*;

  logic      v3_r, v4_r;
  sfas_sum_t s_r;
  logic [5:0] p_r, p_nxt;
  sfas_out_t o_r, o_nxt;

  always_comb begin
    p_nxt = '0;
    for (int i = 0; i < 63; i++) begin
      if (mid_data.r[i]) begin
        p_nxt = 6'(i);
      end
    end
  end

  logic [62:0] rn;
  logic signed [9:0] e;
  always_comb begin
    if (s_r.r[62]) begin
      rn = s_r.r >> 1;
    end else begin
      rn = s_r.r << (6'd61 - p_r);
    end
    e = $signed({2'b0, s_r.ex}) + $signed({4'b0, p_r}) - 10'sd61;
    if (s_r.r[62]) begin
      e = $signed({2'b0, s_r.ex}) + 10'sd1;
    end
    if (s_r.done) begin
      o_nxt = s_r.early;
    end else if (e >= 10'sd255) begin
      o_nxt = '{s_r.sx, EXP_MAX, 23'd0, 1'b1};
    end else if (e <= 10'sd0) begin
      o_nxt = '0;
    end else begin
      o_nxt = '{s_r.sx, e[7:0], rn[60:38], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v3_r <= mid_valid;
      v4_r <= v3_r;
    end
    s_r <= mid_data;
    p_r <= p_nxt;
    o_r <= o_nxt;
  end

  assign out_valid = v4_r;
  assign out_data = o_r;
endmodule

### design/sfas_checker.sv
// Port-level assertions for the single-precision add/subtract core.
// Depends on sfas_pkg; bound to single_float_add_sub_core.
module sfas_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input sfas_pkg::sfas_out_t out_data,
  input logic                out_valid
);
  import sfas_pkg::*;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##4 (out_valid || !$past(rst_n, 3)))
    else $error("Result missing four cycles after a transaction.");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 4))
    else $error("Result without a transaction.");

  a_inf_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.sum_exponent == EXP_MAX) |-> out_data.exception_flag)
    else $error("Saturated result without exception flag.");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.sum_exponent == 8'd0) |->
      (!out_data.sum_sign || out_data.sum_mantissa != 23'd0))
    else $error("Negative zero produced.");
endmodule

bind single_float_add_sub_core sfas_checker u_sfas_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_data(out_data), .out_valid(out_valid)
);
